### hdl/lbp_pkg.sv
// Shared types, constants and tables for the lidar beam-to-point block.
// No dependencies; used by every module under hdl/.
package lbp_pkg;

    localparam int MAX_BEAMS_DEF    = 4096;
    localparam int CORDIC_STEPS_DEF = 24;

    // field widths fixed by the interface
    localparam int RANGE_W  = 24;
    localparam int ANGLE_W  = 32;
    localparam int XY_W     = 25;
    localparam int VAR_W    = 32;
    localparam int BEAMNO_W = 12;
    localparam int KEEP_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W    = 32;
    localparam int XINIT_W  = 40;

    // CORDIC gain 1/K as Q0.32
    localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
    localparam logic [23:0] XY_LIMIT = 24'hFF_FFFF;

    // arctan(2^-i) in binary angle units
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_START    = 3'd0,
        REG_ANGLE_STEP     = 3'd1,
        REG_RANGE_FLOOR    = 3'd2,
        REG_RANGE_CEILING  = 3'd3,
        REG_RANGE_NOISE_SQ = 3'd4,
        REG_ANGLE_NOISE_SQ = 3'd5,
        REG_SCAN_KEEP      = 3'd6
    } lbp_reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG,
        S_GAIN,
        S_R2,
        S_HI,
        S_LO,
        S_TERM,
        S_VAR,
        S_WAIT,
        S_OUT
    } lbp_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ROUND,
        C_DONE
    } lbp_rot_state_t;

    typedef struct packed {
        logic                      start;
        logic [XINIT_W-1:0]        x_init;   // gain-scaled range, Q24.16
        logic [ANGLE_W-1:0]        angle;
    } lbp_rot_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
    } lbp_rot_rsp_t;

endpackage

### hdl/lbp_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on lbp_pkg for operand width.
module lbp_mul
(
    input  logic                           clk,
    input  logic [lbp_pkg::MUL_W-1:0]      a,
    input  logic [lbp_pkg::MUL_W-1:0]      b,
    output logic [2*lbp_pkg::MUL_W-1:0]    product
);

    logic [2*lbp_pkg::MUL_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= {{lbp_pkg::MUL_W{1'b0}}, a} * {{lbp_pkg::MUL_W{1'b0}}, b};
    end

    assign product = product_reg;

endmodule

### hdl/lbp_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, then round and clamp.
// Depends on lbp_pkg for the arctangent table, request/response structs and state enum.
module lbp_cordic
#(
    parameter int CORDIC_STEPS = lbp_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbp_pkg::lbp_rot_req_t req,
    output lbp_pkg::lbp_rot_rsp_t rsp
);

    localparam int XW = 42;
    localparam int ZW = 34;
    localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
    localparam logic signed [XW-1:0] LIM_POS = XW'(lbp_pkg::XY_LIMIT);
    localparam logic signed [XW-1:0] LIM_NEG = -XW'(lbp_pkg::XY_LIMIT);

    lbp_pkg::lbp_rot_state_t state_reg, state_next;

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           iter_reg;
    logic signed [lbp_pkg::XY_W-1:0] xo_reg, yo_reg;

    logic                 flip;
    logic [31:0]          ang_fold;
    logic signed [XW-1:0] x_start;
    logic signed [XW-1:0] dx, dy, x_step, y_step;
    logic signed [ZW-1:0] atan_z, z_step;

    function automatic logic signed [lbp_pkg::XY_W-1:0] round_clamp(
        input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        logic signed [XW-1:0] s;
        logic signed [XW-1:0] c;
        r = v + XW'(32768);
        s = r >>> 16;
        if (s > LIM_POS)
            c = LIM_POS;
        else if (s < LIM_NEG)
            c = LIM_NEG;
        else
            c = s;
        return c[lbp_pkg::XY_W-1:0];
    endfunction

    // fold the second and third quadrants by half a turn
    always_comb
    begin
        flip     = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
        ang_fold = flip ? (req.angle ^ 32'h8000_0000) : req.angle;
        x_start  = flip ? -$signed({2'b00, req.x_init}) : $signed({2'b00, req.x_init});
    end

    always_comb
    begin
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        atan_z = $signed({2'b00, lbp_pkg::ATAN_BAM[iter_reg]});
        if (!z_reg[ZW-1])
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - atan_z;
        end
        else
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + atan_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbp_pkg::C_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbp_pkg::C_IDLE:  if (req.start) state_next = lbp_pkg::C_RUN;
            lbp_pkg::C_RUN:   if (iter_reg == LAST_ITER) state_next = lbp_pkg::C_ROUND;
            lbp_pkg::C_ROUND: state_next = lbp_pkg::C_DONE;
            lbp_pkg::C_DONE:  if (req.start) state_next = lbp_pkg::C_RUN;
            default:          state_next = lbp_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.start && state_reg != lbp_pkg::C_RUN)
        begin
            x_reg    <= x_start;
            y_reg    <= '0;
            z_reg    <= {{2{ang_fold[31]}}, ang_fold};
            iter_reg <= '0;
        end
        else if (state_reg == lbp_pkg::C_RUN)
        begin
            x_reg    <= x_step;
            y_reg    <= y_step;
            z_reg    <= z_step;
            iter_reg <= iter_reg + 5'd1;
        end
        if (state_reg == lbp_pkg::C_ROUND)
        begin
            xo_reg <= round_clamp(x_reg);
            yo_reg <= round_clamp(y_reg);
        end
    end

    assign rsp.done = (state_reg == lbp_pkg::C_DONE);
    assign rsp.x    = xo_reg;
    assign rsp.y    = yo_reg;

endmodule

### hdl/lidar_beam_to_point.sv
// Lidar beam to point: gates each beam's range, drops decimated scans and turns
// hits into x/y through an iterative CORDIC, with a variance from one shared
// 32x32 multiplier that the sequencer also uses for the beam angle and CORDIC
// gain. Items are taken one at a time: a beam of a skipped scan is only counted,
// a miss passes the angle, gain and output states, and a hit also runs the variance
// states and waits on the one-step-per-cycle CORDIC loop. A finished result waits in
// an output register, so the next beam is taken while the previous one stalls.
// Depends on lbp_pkg, lbp_mul and lbp_cordic.
module lidar_beam_to_point
#(
    parameter int MAX_BEAMS    = lbp_pkg::MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = lbp_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lbp_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lbp_pkg::RANGE_W-1:0]          sample_range,
    input  logic                                 not_finite,
    input  logic                                 scan_start,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic signed [lbp_pkg::ANGLE_W-1:0]   beam_angle,
    output logic [lbp_pkg::RANGE_W-1:0]          ray_range,
    output logic signed [lbp_pkg::XY_W-1:0]      point_x,
    output logic signed [lbp_pkg::XY_W-1:0]      point_y,
    output logic [lbp_pkg::VAR_W-1:0]            point_variance,
    output logic [lbp_pkg::BEAMNO_W-1:0]         beam_number
);

    localparam int BW = $clog2(MAX_BEAMS);
    localparam logic [BW-1:0] BEAM_LAST = BW'(MAX_BEAMS - 1);
    localparam int MW = lbp_pkg::MUL_W;

    // configuration
    logic [31:0] angle_start_reg, angle_step_reg;
    logic [23:0] range_floor_reg, range_ceiling_reg;
    logic [31:0] range_noise_sq_reg, angle_noise_sq_reg;
    logic [15:0] scan_keep_reg;

    // scan state
    logic [BW-1:0] beam_index_reg, beam_index_next;
    logic [15:0]   scan_counter_reg, scan_counter_next;
    logic          scan_kept_reg, scan_kept_next;

    lbp_pkg::lbp_state_t state_reg, state_next;

    // item and working registers
    logic [23:0]   r_reg;
    logic          hit_reg;
    logic [BW-1:0] cur_reg;
    logic [31:0]   angle_reg;
    logic [23:0]   lo_reg;
    logic [55:0]   hiprod_reg;
    logic [32:0]   term_reg;
    logic [31:0]   var_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        o_hit_reg;
    logic [31:0] o_angle_reg;
    logic [23:0] o_range_reg;
    logic signed [24:0] o_x_reg, o_y_reg;
    logic [31:0] o_var_reg;
    logic [11:0] o_beam_reg;

    logic in_xfer, out_xfer, load_out;
    logic [MW-1:0]   mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic [31:0]     cur_ext;
    logic [15:0]     keep_eff;
    logic [16:0]     cnt_inc;
    logic            in_hit;
    logic [31:0]     sr2;
    logic [33:0]     var_sum;

    lbp_pkg::lbp_rot_req_t rot_req;
    lbp_pkg::lbp_rot_rsp_t rot_rsp;

    lbp_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    lbp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rot_req),
        .rsp   (rot_rsp)
    );

    assign in_stall = (state_reg != lbp_pkg::S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign cur_ext  = 32'(cur_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg    <= '0;
            angle_step_reg     <= '0;
            range_floor_reg    <= '0;
            range_ceiling_reg  <= 24'hFF_FFFF;
            range_noise_sq_reg <= 32'd1;
            angle_noise_sq_reg <= '0;
            scan_keep_reg      <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lbp_pkg::REG_ANGLE_START:    angle_start_reg    <= cfg_data;
                lbp_pkg::REG_ANGLE_STEP:     angle_step_reg     <= cfg_data;
                lbp_pkg::REG_RANGE_FLOOR:    range_floor_reg    <= cfg_data[23:0];
                lbp_pkg::REG_RANGE_CEILING:  range_ceiling_reg  <= cfg_data[23:0];
                lbp_pkg::REG_RANGE_NOISE_SQ: range_noise_sq_reg <= cfg_data;
                lbp_pkg::REG_ANGLE_NOISE_SQ: angle_noise_sq_reg <= cfg_data;
                lbp_pkg::REG_SCAN_KEEP:      scan_keep_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // scan decimation and beam numbering
    always_comb
    begin
        keep_eff          = (scan_keep_reg == '0) ? 16'd1 : scan_keep_reg;
        cnt_inc           = {1'b0, scan_counter_reg} + 17'd1;
        scan_counter_next = scan_counter_reg;
        scan_kept_next    = scan_kept_reg;
        beam_index_next   = beam_index_reg;
        if (in_xfer)
        begin
            if (scan_start)
            begin
                scan_kept_next    = (scan_counter_reg == '0);
                scan_counter_next = (cnt_inc >= {1'b0, keep_eff}) ? '0 : cnt_inc[15:0];
                beam_index_next   = '0;
            end
            if (beam_index_next < BEAM_LAST)
                beam_index_next = beam_index_next + BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_index_reg   <= '0;
            scan_counter_reg <= '0;
            scan_kept_reg    <= 1'b1;
        end
        else
        begin
            beam_index_reg   <= beam_index_next;
            scan_counter_reg <= scan_counter_next;
            scan_kept_reg    <= scan_kept_next;
        end
    end

    assign in_hit = !not_finite && (sample_range >= range_floor_reg)
                    && (sample_range <= range_ceiling_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mul_a          = '0;
        mul_b          = '0;
        rot_req.start  = 1'b0;
        rot_req.x_init = mul_p[55:16];
        rot_req.angle  = angle_reg;
        load_out       = 1'b0;
        unique case (state_reg)
            lbp_pkg::S_IDLE:
            begin
                if (in_xfer && scan_kept_next)
                    state_next = lbp_pkg::S_ANG;
            end
            lbp_pkg::S_ANG:
            begin
                mul_a      = cur_ext;
                mul_b      = angle_step_reg;
                state_next = lbp_pkg::S_GAIN;
            end
            lbp_pkg::S_GAIN:
            begin
                mul_a      = 32'(r_reg);
                mul_b      = lbp_pkg::GAIN_Q32;
                state_next = hit_reg ? lbp_pkg::S_R2 : lbp_pkg::S_OUT;
            end
            lbp_pkg::S_R2:
            begin
                rot_req.start = 1'b1;
                mul_a         = 32'(r_reg);
                mul_b         = 32'(r_reg);
                state_next    = lbp_pkg::S_HI;
            end
            lbp_pkg::S_HI:
            begin
                mul_a      = 32'(mul_p[47:24]);
                mul_b      = angle_noise_sq_reg;
                state_next = lbp_pkg::S_LO;
            end
            lbp_pkg::S_LO:
            begin
                mul_a      = 32'(lo_reg);
                mul_b      = angle_noise_sq_reg;
                state_next = lbp_pkg::S_TERM;
            end
            lbp_pkg::S_TERM: state_next = lbp_pkg::S_VAR;
            lbp_pkg::S_VAR:  state_next = lbp_pkg::S_WAIT;
            lbp_pkg::S_WAIT:
            begin
                if (rot_rsp.done)
                    state_next = lbp_pkg::S_OUT;
            end
            lbp_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = lbp_pkg::S_IDLE;
                end
            end
            default: state_next = lbp_pkg::S_IDLE;
        endcase
    end

    assign sr2     = (range_noise_sq_reg == '0) ? 32'd1 : range_noise_sq_reg;
    assign var_sum = {1'b0, term_reg} + 34'(sr2);

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            r_reg   <= sample_range;
            hit_reg <= in_hit;
            cur_reg <= scan_start ? '0 : beam_index_reg;
        end
        if (state_reg == lbp_pkg::S_GAIN)
            angle_reg <= angle_start_reg + mul_p[31:0];
        if (state_reg == lbp_pkg::S_HI)
            lo_reg <= mul_p[23:0];
        if (state_reg == lbp_pkg::S_LO)
            hiprod_reg <= mul_p[55:0];
        if (state_reg == lbp_pkg::S_TERM)
            term_reg <= 33'((57'(hiprod_reg) + 57'(mul_p[55:24])) >> 24);
        if (state_reg == lbp_pkg::S_VAR)
            var_reg <= var_sum[33:32] != 2'b00 ? 32'hFFFF_FFFF : var_sum[31:0];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_xfer)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_hit_reg   <= hit_reg;
            o_angle_reg <= angle_reg;
            o_range_reg <= hit_reg ? r_reg : range_ceiling_reg;
            o_x_reg     <= hit_reg ? rot_rsp.x : '0;
            o_y_reg     <= hit_reg ? rot_rsp.y : '0;
            o_var_reg   <= hit_reg ? var_reg : '0;
            o_beam_reg  <= cur_ext[11:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = o_hit_reg;
    assign beam_angle     = o_angle_reg;
    assign ray_range      = o_range_reg;
    assign point_x        = o_x_reg;
    assign point_y        = o_y_reg;
    assign point_variance = o_var_reg;
    assign beam_number    = o_beam_reg;

    // a new result only comes out of the output state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lbp_pkg::S_OUT))
        else $error("result appeared outside the output state");

    // misses carry no point and no variance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !o_hit_reg) |->
            (o_x_reg == '0 && o_y_reg == '0 && o_var_reg == '0))
        else $error("miss result with nonzero point data");

    // hits always have a nonzero variance
    a_hit_var: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_hit_reg) |-> (o_var_reg != '0))
        else $error("hit result with zero variance");

    // the beam counter saturates at the last beam
    a_beam_sat: assert property (@(posedge clk) disable iff (!rst_n)
        beam_index_reg <= BEAM_LAST)
        else $error("beam index beyond its limit");

    // the rotation is never restarted while the sequencer waits on it
    a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lbp_pkg::S_WAIT) |-> !rot_req.start)
        else $error("rotation restarted while waiting for it");

endmodule
